### src/aeskx_pkg.sv
// Shared types, constants and helpers for the AES-128 key expansion unit.
package aeskx_pkg;

  localparam int IDX_W = 6;

  localparam logic [IDX_W-1:0] FIRST_DERIVED = 6'd4;
  localparam logic [IDX_W-1:0] LAST_IDX      = 6'd43;

  localparam logic [7:0] RCON_SEED = 8'h8d;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             sbox_wr;   // store one S-box byte in every lane bank
    logic             key_load;  // echo a key word and shift it into the window
    logic             gen;       // produce the next derived word
    logic             sub_step;  // derived word uses RotWord, SubWord and Rcon
    logic             rcon_init; // restart the round constant
    logic [IDX_W-1:0] idx;       // word index of the beat being loaded
    logic             last;      // loaded beat is the final word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a beat this cycle
  } sts_t;

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    logic [7:0] r;
    r = {b[6:0], 1'b0};
    if (b[7]) begin
      r = r ^ GF_POLY;
    end
    return r;
  endfunction

endpackage

### src/aeskx_ctrl.sv
// Sequencer of the key expansion: input acceptance, key word count and word index.
module aeskx_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic            s_tuser,    // mode: 0 S-box write, 1 key word
  input  aeskx_pkg::sts_t sts,
  output aeskx_pkg::cmd_t cmd
);
  import aeskx_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_GEN    = 2'd2;

  localparam logic MODE_SBOX = 1'b0;
  localparam logic MODE_KEY  = 1'b1;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [1:0]       seen;
  logic [1:0]       seen_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             accept;

  assign s_tready = (state == ST_IDLE) && sts.out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next    = state;
    seen_next     = seen;
    idx_next      = idx;
    cmd           = '0;
    cmd.idx       = idx;
    cmd.sub_step  = (idx[1:0] == 2'd0);
    unique case (state)
      ST_IDLE: begin
        cmd.idx = {{(IDX_W-2){1'b0}}, seen};
        if (accept) begin
          if (s_tuser == MODE_SBOX) begin
            cmd.sbox_wr = 1'b1;
          end else begin
            cmd.key_load = 1'b1;
            seen_next    = 2'(seen + 2'd1);
            if (seen == 2'd3) begin
              cmd.rcon_init = 1'b1;
              idx_next      = FIRST_DERIVED;
              state_next    = ST_LOOKUP;
            end
          end
        end
      end
      ST_LOOKUP: begin
        // The S-box banks register the substituted word before generation can use it.
        state_next = ST_GEN;
      end
      ST_GEN: begin
        cmd.last = (idx == LAST_IDX);
        if (sts.out_free) begin
          cmd.gen  = 1'b1;
          idx_next = IDX_W'(idx + 6'd1);
          if (idx == LAST_IDX) begin
            state_next = ST_IDLE;
          end else if (idx[1:0] == 2'd3) begin
            state_next = ST_LOOKUP;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seen  <= 2'd0;
      idx   <= '0;
    end else begin
      state <= state_next;
      seen  <= seen_next;
      idx   <= idx_next;
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("input accepted while a schedule is running");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN || state == ST_LOOKUP) |-> (idx >= FIRST_DERIVED && idx <= LAST_IDX))
    else $error("word index out of the derived range");

  a_lookup_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |=> (state == ST_GEN))
    else $error("S-box lookup did not hand over to generation");

  a_lookup_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> (idx[1:0] == 2'd0))
    else $error("S-box lookup on a word that takes no substitution");

  a_key_mode_const: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == MODE_KEY && seen == 2'd3) |=> (state == ST_LOOKUP))
    else $error("fourth key word did not start the schedule");

endmodule

### src/aeskx_datapath.sv
// Datapath: S-box banks, word window, round constant and output register.
module aeskx_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic [47:0]     s_tdata,   // sbox_index[7:0], sbox_value[15:8], key_word[47:16]
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [39:0]     m_tdata,   // word_index[5:0], round_word[37:6], zero fill
  output logic            m_tlast,   // last_word
  input  aeskx_pkg::cmd_t cmd,
  output aeskx_pkg::sts_t sts
);
  import aeskx_pkg::*;

  logic [7:0]       sbox_index;
  logic [7:0]       sbox_value;
  logic [31:0]      key_word;
  logic [31:0]      win [4];
  logic [31:0]      rot;
  logic [31:0]      sub_q;
  logic [7:0]       rcon;
  logic [7:0]       rcon_dbl;
  logic [31:0]      temp;
  logic [31:0]      word_new;
  logic [31:0]      out_word;
  logic [IDX_W-1:0] out_idx;
  logic             out_last;

  assign sbox_index = s_tdata[7:0];
  assign sbox_value = s_tdata[15:8];
  assign key_word   = s_tdata[47:16];

  // RotWord of the newest word; the window holds the oldest word in slot 0.
  assign rot = {win[3][23:0], win[3][31:24]};

  // One bank per byte lane, so all four substitutions are read together.
  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [7:0] bank [256];

    always_ff @(posedge clk) begin
      if (cmd.sbox_wr) begin
        bank[sbox_index] <= sbox_value;
      end
      sub_q[8*k +: 8] <= bank[rot[8*k +: 8]];
    end
  end

  assign rcon_dbl = gf_double(rcon);
  assign temp     = cmd.sub_step ? (sub_q ^ {rcon_dbl, 24'd0}) : win[3];
  assign word_new = temp ^ win[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        win[i] <= '0;
      end
    end else if (cmd.key_load || cmd.gen) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= cmd.key_load ? key_word : word_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rcon_init) begin
      rcon <= RCON_SEED;
    end else if (cmd.gen && cmd.sub_step) begin
      rcon <= rcon_dbl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.key_load || cmd.gen) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_load || cmd.gen) begin
      out_word <= cmd.key_load ? key_word : word_new;
      out_idx  <= cmd.idx;
      out_last <= cmd.last;
    end
  end

  assign m_tdata      = {2'd0, out_word, out_idx};
  assign m_tlast      = out_last;
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

### src/aes128_key_expansion_unit.sv
// AES-128 key expansion unit with a loadable S-box.
//
// Input channel s_*: s_tuser selects the beat kind. With s_tuser = 0 the beat
// writes S-box entry sbox_index with sbox_value; every entry must be written
// before a schedule reads it. With s_tuser = 1 the beat carries the next of the
// four cipher key words, first key byte in bits 31 to 24 of key_word.
// Output channel m_*: one beat per round key word with its index; m_tlast
// marks word 43.
// Each key word is echoed as word 0 to 3 from the output register in the cycle
// after it is taken. The fourth key word then starts the schedule and yields 41
// beats: words 4 to 43 follow at one per cycle while the receiver does not
// stall, with an S-box read state before every fourth word, since the S-box
// banks read through a register. No input is taken while the schedule runs.
// S-box writes can be taken back to back.
// A stall on m_tready holds the output register and the schedule; input is
// also held off while a result waits and the register cannot drain.
// Reset (rst, synchronous) empties the output, clears the key word count and
// the word window; S-box contents are not reset, and are undefined until written.
module aes128_key_expansion_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // sbox_index[7:0], sbox_value[15:8], key_word[47:16]
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // word_index[5:0], round_word[37:6], zero fill
  output logic        m_tlast    // last_word
);
  import aeskx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  aeskx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  aeskx_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

### verif/aeskx_schedule_checker.sv
// Beat kinds shared by the bench, and the checker that predicts and compares round key words.
package aeskx_tb_pkg;

  typedef enum logic {
    MODE_SBOX = 1'b0,
    MODE_KEY  = 1'b1
  } beat_mode_e;

endpackage

module aeskx_schedule_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // sbox_index[7:0], sbox_value[15:8], key_word[47:16]
  input  logic        s_tuser,   // mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // word_index[5:0], round_word[37:6], zero fill
  input  logic        m_tlast,   // last_word
  output int          fail_count,
  output int          due_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import aeskx_tb_pkg::*;

  localparam logic [7:0] RCON_START  = 8'h8d;
  localparam logic [7:0] REDUCE_POLY = 8'h1b;
  localparam logic [5:0] FINAL_INDEX = 6'd43;

  typedef struct {
    logic [5:0]  index;
    logic [31:0] word;
    logic        last;
  } round_word_t;

  logic [7:0]  sbox_mem [256];
  logic [31:0] sched_win [4];
  logic [1:0]  key_slot;
  round_word_t round_words_due [$];

  initial begin
    fail_count = 0;
    due_count  = 0;
  end

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? REDUCE_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
    return {sbox_mem[w[31:24]], sbox_mem[w[23:16]], sbox_mem[w[15:8]], sbox_mem[w[7:0]]};
  endfunction

  // Applies one accepted input beat to the model and queues the words it produces.
  task automatic expand_key_beat(input beat_mode_e mode, input logic [7:0] sb_index,
                                 input logic [7:0] sb_value, input logic [31:0] key_word);
    logic [1:0]  slot;
    logic [31:0] t;
    logic [31:0] rot;
    logic [7:0]  rcon;
    round_word_t rw;
    if (mode == MODE_SBOX) begin
      sbox_mem[sb_index] = sb_value;
      return;
    end
    slot = key_slot;
    sched_win[slot] = key_word;
    rw.index = {4'd0, slot};
    rw.word  = key_word;
    rw.last  = 1'b0;
    round_words_due.push_back(rw);
    key_slot = slot + 2'd1;
    if (slot != 2'd3) begin
      return;
    end
    rcon = RCON_START;
    for (int i = 4; i <= 43; i++) begin
      t = sched_win[2'(i - 1)];
      if (i % 4 == 0) begin
        rot  = {t[23:0], t[31:24]};
        rcon = xtime(rcon);
        t    = sub_bytes_word(rot) ^ {rcon, 24'h000000};
      end
      t = t ^ sched_win[2'(i)];
      sched_win[2'(i)] = t;
      rw.index = i[5:0];
      rw.word  = t;
      rw.last  = (i[5:0] == FINAL_INDEX);
      round_words_due.push_back(rw);
    end
  endtask

  task automatic check_round_word();
    round_word_t want;
    if (round_words_due.size() == 0) begin
      $display("%0t: unexpected beat: word_index %0d round_word %08h last %0b", $time,
               m_tdata[5:0], m_tdata[37:6], m_tlast);
      fail_count++;
      return;
    end
    want = round_words_due.pop_front();
    if (m_tdata[5:0] !== want.index) begin
      $display("%0t: word_index expected %0d, got %0d", $time, want.index, m_tdata[5:0]);
      fail_count++;
    end
    if (m_tdata[37:6] !== want.word) begin
      $display("%0t: round_word %0d expected %08h, got %08h", $time, want.index, want.word,
               m_tdata[37:6]);
      fail_count++;
    end
    if (m_tlast !== want.last) begin
      $display("%0t: last_word of word %0d expected %0b, got %0b", $time, want.index,
               want.last, m_tlast);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_slot = 2'd0;
      for (int k = 0; k < 4; k++) begin
        sched_win[k] = 32'h0;
      end
      round_words_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        check_round_word();
      end
      if (s_tvalid && s_tready) begin
        expand_key_beat(beat_mode_e'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tdata[47:16]);
      end
    end
    due_count = round_words_due.size();
  end

endmodule

### verif/tb.sv
// Top-level bench: drives S-box writes and cipher keys into the key expansion unit.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import aeskx_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // sbox_index[7:0], sbox_value[15:8], key_word[47:16]
  logic        s_tuser;   // mode
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // word_index[5:0], round_word[37:6], zero fill
  logic        m_tlast;   // last_word
  int          fail_count;
  int          due_count;
  logic        s_quiet;
  logic        m_quiet;

  aes128_key_expansion_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  aeskx_schedule_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken,
  // with tvalid still high so that a back-to-back beat needs no extra assignment.
  task automatic send_beat(input beat_mode_e mode, input logic [7:0] sb_index,
                           input logic [7:0] sb_value, input logic [31:0] key_word);
    int gap;
    if ($urandom_range(0, 15) == 0) begin
      s_quiet = ~s_quiet;
    end
    gap = s_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {key_word, sb_value, sb_index};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_key(input logic [31:0] w0, input logic [31:0] w1,
                          input logic [31:0] w2, input logic [31:0] w3);
    send_beat(MODE_KEY, 8'($urandom), 8'($urandom), w0);
    send_beat(MODE_KEY, 8'($urandom), 8'($urandom), w1);
    send_beat(MODE_KEY, 8'($urandom), 8'($urandom), w2);
    send_beat(MODE_KEY, 8'($urandom), 8'($urandom), w3);
  endtask

  // Receiver: a fresh stall length for every result beat.
  initial begin
    int stall;
    m_tready = 1'b0;
    m_quiet  = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        m_quiet = ~m_quiet;
      end
      stall = m_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int pick;
    logic [31:0] word;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = MODE_SBOX;
    s_tdata  = '0;
    s_quiet  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every S-box entry is written before any schedule can read it.
    for (int n = 0; n < 256; n++) begin
      send_beat(MODE_SBOX, n[7:0], 8'($urandom), $urandom);
    end

    send_beat(MODE_SBOX, 8'h00, 8'h00, 32'hffffffff);
    send_beat(MODE_SBOX, 8'hff, 8'hff, 32'h00000000);
    send_key(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
    send_key(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    // S-box writes between key words must reach the schedule of that key.
    send_beat(MODE_KEY, 8'h00, 8'h00, 32'h2b7e1516);
    send_beat(MODE_KEY, 8'hff, 8'hff, 32'h28aed2a6);
    send_beat(MODE_SBOX, 8'h09, 8'hff, 32'h00000000);
    send_beat(MODE_KEY, 8'h00, 8'hff, 32'habf71588);
    send_beat(MODE_SBOX, 8'h3c, 8'h00, 32'hffffffff);
    send_beat(MODE_KEY, 8'hff, 8'h00, 32'h09cf4f3c);
    send_key(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);

    for (int n = 0; n < 230; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(MODE_SBOX, 8'($urandom), 8'($urandom), $urandom);
      end else begin
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
          word = 32'h00000000;
        end else if (pick == 1) begin
          word = 32'hffffffff;
        end else begin
          word = $urandom;
        end
        send_beat(MODE_KEY, 8'($urandom), 8'($urandom), word);
      end
    end
    s_tvalid <= 1'b0;

    while (due_count != 0) @(negedge clk);
    // Room for any stray beat from a schedule still in flight.
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
